// File: rtl/core/smd_pkg.sv
// Shared types and constants for the SHA-1 digest unit.
// No dependencies; imported by every module of the block.
`default_nettype none

package smd_pkg;

   localparam int WORD_W = 32;
   localparam int BLOCK_WORDS = 16;
   localparam int ROUNDS = 80;
   localparam int ROUND_STAGE = 20;
   localparam int QUEUE_DEPTH_DEFAULT = 16;

   localparam logic [WORD_W-1:0] CHAIN_IV [5] = '{
      32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
   };

   localparam logic [WORD_W-1:0] ROUND_K [4] = '{
      32'h5a827999, 32'h6ed9eba1, 32'h8f1bbcdc, 32'hca62c1d6
   };

   typedef enum logic {
      CMD_WORD,
      CMD_DIGEST
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type      kind;
      logic [WORD_W-1:0] word;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

`default_nettype wire

// File: rtl/core/smd_if.sv
// Valid/ready channel interfaces for the SHA-1 digest unit.
// Request carries one message byte; response carries the 160-bit digest.
`default_nettype none

interface smd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       is_last;
   logic       no_byte;

   modport source (output valid, output data_byte, output is_last, output no_byte,
                   input ready);
   modport sink (input valid, input data_byte, input is_last, input no_byte,
                 output ready);
endinterface

interface smd_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word0;
   logic [31:0] digest_word1;
   logic [31:0] digest_word2;
   logic [31:0] digest_word3;
   logic [31:0] digest_word4;

   modport source (output valid, output digest_word0, output digest_word1,
                   output digest_word2, output digest_word3, output digest_word4,
                   input ready);
   modport sink (input valid, input digest_word0, input digest_word1,
                 input digest_word2, input digest_word3, input digest_word4,
                 output ready);
endinterface

`default_nettype wire

// File: rtl/core/smd_front.sv
// Front end: packs message bytes into big-endian words, counts length,
// and emits padding, length words and the digest command. Uses smd_pkg, smd_req_if.
`default_nettype none

module smd_front import smd_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   smd_req_if.sink      req_chan,
   input  q_status_type q_status,
   output logic         push_valid,
   output cmd_type      push_cmd
);

   typedef enum logic [2:0] {
      F_TAKE,
      F_PAD_MARK,
      F_PAD_ZERO,
      F_LEN_HI,
      F_LEN_LO,
      F_DIGEST
   } fstate_type;

   fstate_type         state_ff, state_in;
   logic [5:0]         pos_ff, pos_in;
   logic [60:0]        count_ff, count_in;
   logic [WORD_W-1:0]  acc_ff, acc_in;

   logic               space;
   logic               accept;
   logic [4:0]         lane_shift;
   logic [WORD_W-1:0]  merged;
   logic [WORD_W-1:0]  mark_word;
   logic [5:0]         next_word_pos;

   assign space         = !q_status.full;
   assign req_chan.ready = (state_ff == F_TAKE) && space;
   assign accept        = req_chan.valid && req_chan.ready;
   assign lane_shift    = {~pos_ff[1:0], 3'b000};
   assign merged        = acc_ff | (WORD_W'(req_chan.data_byte) << lane_shift);
   assign mark_word     = acc_ff | (WORD_W'(8'h80) << lane_shift);
   assign next_word_pos = {pos_ff[5:2] + 4'd1, 2'b00};

   always_comb begin
      state_in   = state_ff;
      pos_in     = pos_ff;
      count_in   = count_ff;
      acc_in     = acc_ff;
      push_valid = 1'b0;
      push_cmd   = '{kind: CMD_WORD, word: merged};
      unique case (state_ff)
         F_TAKE: begin
            if (accept) begin
               if (!req_chan.no_byte) begin
                  count_in = count_ff + 61'd1;
                  pos_in   = pos_ff + 6'd1;
                  if (pos_ff[1:0] == 2'b11) begin
                     push_valid = 1'b1;
                     acc_in     = '0;
                  end else begin
                     acc_in = merged;
                  end
               end
               if (req_chan.is_last) begin
                  state_in = F_PAD_MARK;
               end
            end
         end
         F_PAD_MARK: begin
            push_cmd.word = mark_word;
            if (space) begin
               push_valid = 1'b1;
               acc_in     = '0;
               pos_in     = next_word_pos;
               state_in   = F_PAD_ZERO;
            end
         end
         F_PAD_ZERO: begin
            push_cmd.word = '0;
            if (pos_ff[5:2] == 4'd14) begin
               state_in = F_LEN_HI;
            end else if (space) begin
               push_valid = 1'b1;
               pos_in     = next_word_pos;
            end
         end
         F_LEN_HI: begin
            push_cmd.word = count_ff[60:29];
            if (space) begin
               push_valid = 1'b1;
               pos_in     = next_word_pos;
               state_in   = F_LEN_LO;
            end
         end
         F_LEN_LO: begin
            push_cmd.word = {count_ff[28:0], 3'b000};
            if (space) begin
               push_valid = 1'b1;
               pos_in     = next_word_pos;
               state_in   = F_DIGEST;
            end
         end
         F_DIGEST: begin
            push_cmd = '{kind: CMD_DIGEST, word: '0};
            if (space) begin
               push_valid = 1'b1;
               pos_in     = '0;
               count_in   = '0;
               acc_in     = '0;
               state_in   = F_TAKE;
            end
         end
         default: state_in = F_TAKE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_TAKE;
         pos_ff   <= '0;
         count_ff <= '0;
         acc_ff   <= '0;
      end else begin
         state_ff <= state_in;
         pos_ff   <= pos_in;
         count_ff <= count_in;
         acc_ff   <= acc_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/smd_queue.sv
// Command queue between front end and compression engine.
// Register-file FIFO of smd_pkg::cmd_type entries; uses smd_pkg.
`default_nettype none

module smd_queue import smd_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push_valid,
   input  cmd_type      push_cmd,
   input  wire logic    pop,
   output cmd_type      head,
   output q_status_type status
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   cmd_type             mem_ff [DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;

   assign head         = mem_ff[rd_ptr_ff];
   assign status.full  = (count_ff == CNT_W'(DEPTH));
   assign status.empty = (count_ff == '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_valid) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push_valid && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push_valid) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push_valid && !pop |-> !status.full)
      else $error("queue push while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !status.empty)
      else $error("queue pop while empty");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue fill count out of range");

endmodule

`default_nettype wire

// File: rtl/core/smd_back.sv
// Compression engine: loads 16 schedule words, runs 80 rounds at one per cycle,
// folds into the chain values and registers the digest. Uses smd_pkg, smd_rsp_if.
`default_nettype none

module smd_back import smd_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   input  cmd_type   head,
   input  wire logic q_empty,
   output logic      pop,
   smd_rsp_if.source rsp_chan
);

   typedef enum logic [1:0] {
      B_LOAD,
      B_ROUND,
      B_ADD
   } bstate_type;

   bstate_type          state_ff, state_in;
   logic [3:0]          widx_ff, widx_in;
   logic [6:0]          round_ff, round_in;
   logic [WORD_W-1:0]   work_ff [5];
   logic [WORD_W-1:0]   work_in [5];
   logic [WORD_W-1:0]   chain_ff [5];
   logic [WORD_W-1:0]   chain_in [5];
   logic [WORD_W-1:0]   win_ff [BLOCK_WORDS];
   logic [WORD_W-1:0]   win_in [BLOCK_WORDS];
   logic [WORD_W-1:0]   digest_ff [5];
   logic [WORD_W-1:0]   digest_in [5];
   logic                rsp_valid_ff, rsp_valid_in;

   logic                out_free;
   logic [1:0]          stage;
   logic [WORD_W-1:0]   a, b, c, d, e;
   logic [WORD_W-1:0]   f;
   logic [WORD_W-1:0]   mix;
   logic [WORD_W-1:0]   new_w;
   logic [WORD_W-1:0]   tmp;

   assign a = work_ff[0];
   assign b = work_ff[1];
   assign c = work_ff[2];
   assign d = work_ff[3];
   assign e = work_ff[4];

   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign pop = (state_ff == B_LOAD) && !q_empty &&
                ((head.kind == CMD_WORD) || out_free);

   always_comb begin
      if (round_ff < 7'(ROUND_STAGE)) begin
         stage = 2'd0;
      end else if (round_ff < 7'(2 * ROUND_STAGE)) begin
         stage = 2'd1;
      end else if (round_ff < 7'(3 * ROUND_STAGE)) begin
         stage = 2'd2;
      end else begin
         stage = 2'd3;
      end
      case (stage)
         2'd0:    f = (b & c) | (~b & d);
         2'd2:    f = (b & c) | (b & d) | (c & d);
         default: f = b ^ c ^ d;
      endcase
   end

   assign mix   = win_ff[13] ^ win_ff[8] ^ win_ff[2] ^ win_ff[0];
   assign new_w = {mix[WORD_W-2:0], mix[WORD_W-1]};
   assign tmp   = {a[WORD_W-6:0], a[WORD_W-1:WORD_W-5]} + f + e + win_ff[0] + ROUND_K[stage];

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.digest_word0 = digest_ff[0];
   assign rsp_chan.digest_word1 = digest_ff[1];
   assign rsp_chan.digest_word2 = digest_ff[2];
   assign rsp_chan.digest_word3 = digest_ff[3];
   assign rsp_chan.digest_word4 = digest_ff[4];

   always_comb begin
      state_in     = state_ff;
      widx_in      = widx_ff;
      round_in     = round_ff;
      work_in      = work_ff;
      chain_in     = chain_ff;
      win_in       = win_ff;
      digest_in    = digest_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      unique case (state_ff)
         B_LOAD: begin
            if (pop) begin
               if (head.kind == CMD_WORD) begin
                  for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
                     win_in[i] = win_ff[i+1];
                  end
                  win_in[BLOCK_WORDS-1] = head.word;
                  widx_in = widx_ff + 4'd1;
                  if (widx_ff == 4'(BLOCK_WORDS - 1)) begin
                     state_in = B_ROUND;
                     work_in  = chain_ff;
                     round_in = '0;
                  end
               end else begin
                  rsp_valid_in = 1'b1;
                  digest_in    = chain_ff;
                  chain_in     = CHAIN_IV;
               end
            end
         end
         B_ROUND: begin
            for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
               win_in[i] = win_ff[i+1];
            end
            win_in[BLOCK_WORDS-1] = new_w;
            work_in[0] = tmp;
            work_in[1] = a;
            work_in[2] = {b[1:0], b[WORD_W-1:2]};
            work_in[3] = c;
            work_in[4] = d;
            round_in   = round_ff + 7'd1;
            if (round_ff == 7'(ROUNDS - 1)) begin
               state_in = B_ADD;
            end
         end
         B_ADD: begin
            for (int i = 0; i < 5; i++) begin
               chain_in[i] = chain_ff[i] + work_ff[i];
            end
            state_in = B_LOAD;
         end
         default: state_in = B_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      win_ff    <= win_in;
      digest_ff <= digest_in;
      if (reset) begin
         state_ff     <= B_LOAD;
         widx_ff      <= '0;
         round_ff     <= '0;
         work_ff      <= '{default: '0};
         chain_ff     <= CHAIN_IV;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         widx_ff      <= widx_in;
         round_ff     <= round_in;
         work_ff      <= work_in;
         chain_ff     <= chain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_digest_on_boundary: assert property (@(posedge clock) disable iff (reset)
      pop && (head.kind == CMD_DIGEST) |-> widx_ff == '0)
      else $error("digest command inside a partial block");

   a_round_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == B_ROUND |-> round_ff < 7'(ROUNDS))
      else $error("round counter out of range");

endmodule

`default_nettype wire

// File: rtl/core/sha1_message_digest_unit.sv
// SHA-1 message digest unit, top level.
// Uses smd_pkg, smd_if, smd_front, smd_queue, smd_back.
//
// req_chan takes one message byte per transfer (no_byte set: no byte,
// is_last set: message ends). rsp_chan gives one 160-bit digest, five
// big-endian words, per message. Both are valid/ready channels.
// The front end takes one byte per cycle and packs words into a command
// queue (QUEUE_DEPTH entries); it stalls when the queue is full and while
// it writes the padding, the length and the digest command.
// The compression engine loads one word per cycle while the queue holds
// words and runs one round per cycle; for each 64-byte block it loads 16
// words, runs 80 rounds and adds the result into the chain values, and it
// takes no word of the next block until that add is done. After the last
// item the front end writes the padding and the length when the queue has
// room; the digest follows the compression of the one or two padded blocks
// and of any earlier block still in the engine.
// Reset (synchronous) loads the initial chain values, empties the queue and
// the counters; an item can be taken as soon as reset is released.
// While rsp_chan stalls the digest is held; bytes of the next message are
// still taken until the queue fills behind the pending digest command.
`default_nettype none

module sha1_message_digest_unit import smd_pkg::*; #(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input wire logic  clock,
   input wire logic  reset,
   smd_req_if.sink   req_chan,
   smd_rsp_if.source rsp_chan
);

   logic         push_valid;
   cmd_type      push_cmd;
   cmd_type      head;
   q_status_type q_status;
   logic         pop;

   smd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .q_status   (q_status),
      .push_valid (push_valid),
      .push_cmd   (push_cmd)
   );

   smd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .pop        (pop),
      .head       (head),
      .status     (q_status)
   );

   smd_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .q_empty  (q_status.empty),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );

endmodule

`default_nettype wire

// File: tb/sha1_digest_checker.sv
// Watches both channels of the SHA-1 digest unit, predicts each digest and compares it.
// Depends on smd_pkg (chain IV, round constants) and smd_if (channel interfaces).

module sha1_digest_checker import smd_pkg::*; (
   input  logic clock,
   input  logic reset,
   smd_req_if   req_chan,
   smd_rsp_if   rsp_chan,
   output int   mismatch_count,
   output int   digests_outstanding
);

   typedef struct packed {
      logic [31:0] word0;
      logic [31:0] word1;
      logic [31:0] word2;
      logic [31:0] word3;
      logic [31:0] word4;
   } digest_type;

   logic [31:0] chain_h [5];
   logic [31:0] msg_words [16];
   logic [5:0]  block_pos;
   logic [60:0] msg_bytes;
   digest_type  expected_digests [$];

   function automatic logic [31:0] rotl32(input logic [31:0] x, input int n);
      return (x << n) | (x >> (32 - n));
   endfunction

   task automatic restart_chain();
      for (int i = 0; i < 5; i++) chain_h[i] = CHAIN_IV[i];
      block_pos = '0;
      msg_bytes = '0;
   endtask

   task automatic compress_block();
      logic [31:0] a, b, c, d, e, w, f, t;
      a = chain_h[0];
      b = chain_h[1];
      c = chain_h[2];
      d = chain_h[3];
      e = chain_h[4];
      for (int r = 0; r < 80; r++) begin
         if (r < 16) begin
            w = msg_words[r];
         end else begin
            w = rotl32(msg_words[(r - 3) & 15] ^ msg_words[(r - 8) & 15] ^
                       msg_words[(r - 14) & 15] ^ msg_words[r & 15], 1);
            msg_words[r & 15] = w;
         end
         if (r < 20) f = (b & c) | (~b & d);
         else if (r >= 40 && r < 60) f = (b & c) | (b & d) | (c & d);
         else f = b ^ c ^ d;
         t = rotl32(a, 5) + f + e + w + ROUND_K[r / 20];
         e = d;
         d = c;
         c = rotl32(b, 30);
         b = a;
         a = t;
      end
      chain_h[0] += a;
      chain_h[1] += b;
      chain_h[2] += c;
      chain_h[3] += d;
      chain_h[4] += e;
   endtask

   task automatic absorb_byte(input logic [7:0] value);
      if (block_pos[1:0] == 2'd0) msg_words[block_pos[5:2]] = '0;
      msg_words[block_pos[5:2]][8 * (3 - block_pos[1:0]) +: 8] = value;
      if (block_pos == 6'd63) compress_block();
      block_pos = block_pos + 6'd1;
   endtask

   task automatic close_message();
      logic [63:0] bit_len;
      bit_len = {msg_bytes, 3'b000};
      absorb_byte(8'h80);
      while (block_pos != 6'd56) absorb_byte(8'h00);
      for (int i = 7; i >= 0; i--) absorb_byte(bit_len[8 * i +: 8]);
      expected_digests.push_back({chain_h[0], chain_h[1], chain_h[2], chain_h[3], chain_h[4]});
      restart_chain();
   endtask

   task automatic check_word(input string field, input logic [31:0] want,
                             input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %h, got %h", field, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      digest_type want;
      if (reset) begin
         restart_chain();
         expected_digests.delete();
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            if (!req_chan.no_byte) begin
               absorb_byte(req_chan.data_byte);
               msg_bytes = msg_bytes + 61'd1;
            end
            if (req_chan.is_last) close_message();
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_digests.size() == 0) begin
               $error("digest transfer with no message outstanding");
               mismatch_count++;
            end else begin
               want = expected_digests.pop_front();
               check_word("digest_word0", want.word0, rsp_chan.digest_word0);
               check_word("digest_word1", want.word1, rsp_chan.digest_word1);
               check_word("digest_word2", want.word2, rsp_chan.digest_word2);
               check_word("digest_word3", want.word3, rsp_chan.digest_word3);
               check_word("digest_word4", want.word4, rsp_chan.digest_word4);
            end
         end
      end
      digests_outstanding = expected_digests.size();
   end

endmodule

// File: tb/sha1_message_digest_unit_tb.sv
// Top of the SHA-1 digest unit testbench: clock, reset, byte stream stimulus, verdict.
// Depends on smd_if, sha1_message_digest_unit and sha1_digest_checker.

module sha1_message_digest_unit_tb;

   localparam int STIM_ITEMS     = 650;
   localparam int DRAIN_CYCLES   = 300;
   localparam int WATCHDOG_LIMIT = 20000;

   logic clock;
   logic reset;
   int   mismatch_count;
   int   digests_outstanding;
   int   send_idle_pct;
   int   recv_stall_pct;
   int   quiet_cycles;
   int   items_sent;
   int   messages_sent;
   int   phase;

   smd_req_if req_chan ();
   smd_rsp_if rsp_chan ();

   sha1_message_digest_unit dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   sha1_digest_checker digest_checker (
      .clock               (clock),
      .reset               (reset),
      .req_chan            (req_chan),
      .rsp_chan            (rsp_chan),
      .mismatch_count      (mismatch_count),
      .digests_outstanding (digests_outstanding)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_chan.ready <= !reset && ($urandom_range(0, 99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_item(input logic [7:0] value, input logic last, input logic empty);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.data_byte <= value;
      req_chan.is_last   <= last;
      req_chan.no_byte   <= empty;
      do @(posedge clock); while (!req_chan.ready);
      if (last || !empty) items_sent++;
   endtask

   // hold off until every digest in flight has been transferred
   task automatic wait_for_digests();
      req_chan.valid <= 1'b0;
      do @(negedge clock); while (digests_outstanding != 0);
      @(posedge clock);
   endtask

   function automatic int pick_message_length();
      int block_edges [8] = '{55, 56, 57, 63, 64, 65, 119, 120};
      int pick;
      pick = $urandom_range(0, 19);
      if (pick < 14) return $urandom_range(0, 16);
      if (pick < 17) return block_edges[$urandom_range(0, 7)];
      if (pick < 18) return $urandom_range(17, 130);
      return $urandom_range(0, 1);
   endfunction

   task automatic send_message(input int len, input logic end_empty);
      logic last;
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(0, 19) == 0) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
         last = !end_empty && (i == len - 1);
         send_item(8'($urandom_range(0, 255)), last, 1'b0);
      end
      if (end_empty || len == 0) send_item(8'($urandom_range(0, 255)), 1'b1, 1'b1);
      messages_sent++;
   endtask

   initial begin
      req_chan.valid     <= 1'b0;
      req_chan.data_byte <= 8'h00;
      req_chan.is_last   <= 1'b0;
      req_chan.no_byte   <= 1'b0;
      reset              <= 1'b1;
      send_idle_pct  = 31;
      recv_stall_pct = 87;
      items_sent     = 0;
      messages_sent  = 0;
      phase          = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // empty message
      send_item(8'h00, 1'b1, 1'b1);
      // "abc"
      send_item(8'h61, 1'b0, 1'b0);
      send_item(8'h62, 1'b0, 1'b0);
      send_item(8'h63, 1'b1, 1'b0);
      // ignored no-byte items, message ended by a no-byte last
      send_item(8'hff, 1'b0, 1'b1);
      send_item(8'hff, 1'b0, 1'b0);
      send_item(8'h00, 1'b0, 1'b0);
      send_item(8'h5a, 1'b0, 1'b1);
      send_item(8'ha5, 1'b1, 1'b1);
      // single-byte messages at the byte extremes
      send_item(8'h00, 1'b1, 1'b0);
      send_item(8'hff, 1'b1, 1'b0);
      wait_for_digests();

      while (items_sent < STIM_ITEMS) begin
         if (phase == 0 && items_sent >= STIM_ITEMS / 3) begin
            wait_for_digests();
            phase          = 1;
            send_idle_pct  = 87;
            recv_stall_pct = 31;
         end else if (phase == 1 && items_sent >= 2 * STIM_ITEMS / 3) begin
            wait_for_digests();
            phase          = 2;
            send_idle_pct  = 0;
            recv_stall_pct = 0;
         end
         send_message(pick_message_length(), 1'($urandom_range(0, 1)));
      end

      wait_for_digests();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
